@@ rtl/ldrt_pkg.sv @@
`default_nettype none

package ldrt_pkg;

    localparam int CHAR_W          = 7;
    localparam int LEN_W           = 16;
    localparam int ALPHABET_DEF    = 128;
    localparam int MAX_LENGTH_DEF  = 65535;
    localparam int QUEUE_DEPTH     = 2;

    // one result as it leaves the back end
    typedef struct packed {
        logic [LEN_W-1:0] window_length;
        logic [LEN_W-1:0] longest_so_far;
        logic             is_last;
        logic             overflow;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/longest_distinct_run_tracker_core.sv @@
`default_nettype none
// path: an accepted request is loaded into the input stage, then passes through the queue, the
// table read and execute into the output register
// throughput: one request per cycle while i_ready does not stall the output, set by the table read and update
// reset: synchronous active-low i_rst_n empties all stages and marks every character unseen

module longest_distinct_run_tracker_core #(
    parameter int ALPHABET_SIZE     = ldrt_pkg::ALPHABET_DEF,
    parameter int MAX_STRING_LENGTH = ldrt_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [ldrt_pkg::CHAR_W-1:0] i_character,
    input  wire logic                        i_end_of_string,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [ldrt_pkg::LEN_W-1:0]  o_window_length,
    output      logic [ldrt_pkg::LEN_W-1:0]  o_longest_so_far,
    output      logic                        o_is_last,
    output      logic                        o_overflow
);
    import ldrt_pkg::*;

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    logic             w_f_push;
    logic             w_f_ready;
    logic [IDX_W-1:0] w_f_idx;
    logic             w_f_eos;
    logic             w_q_valid;
    logic             w_q_pop;
    logic [IDX_W:0]   w_q_data;
    t_res             w_res;

    ldrt_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .IDX_W         (IDX_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .o_push          (w_f_push),
        .i_push_ready    (w_f_ready),
        .o_idx           (w_f_idx),
        .o_eos           (w_f_eos)
    );

    ldrt_queue #(
        .WIDTH (IDX_W + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_f_push),
        .o_push_ready (w_f_ready),
        .i_data       ({w_f_idx, w_f_eos}),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_data       (w_q_data)
    );

    ldrt_back #(
        .ALPHABET_SIZE     (ALPHABET_SIZE),
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
        .IDX_W             (IDX_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_idx   (w_q_data[IDX_W:1]),
        .i_q_eos   (w_q_data[0]),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_window_length  = w_res.window_length;
    assign o_longest_so_far = w_res.longest_so_far;
    assign o_is_last        = w_res.is_last;
    assign o_overflow       = w_res.overflow;

`ifndef SYNTHESIS
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_window_length == '0 && o_longest_so_far == '0))
        else $error("overflowed result carries nonzero lengths");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow) |->
            (o_window_length != '0 && o_window_length <= o_longest_so_far))
        else $error("window length outside best length");

    a_front_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> w_f_push)
        else $error("accepted request missing from front stage");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/ldrt_front.sv @@
`default_nettype none

module ldrt_front #(
    parameter int ALPHABET_SIZE = ldrt_pkg::ALPHABET_DEF,
    parameter int IDX_W         = $clog2(ALPHABET_SIZE)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic [ldrt_pkg::CHAR_W-1:0] i_character,
    input  wire logic                       i_end_of_string,
    output      logic                       o_push,
    input  wire logic                       i_push_ready,
    output      logic [IDX_W-1:0]           o_idx,
    output      logic                       o_eos
);
    import ldrt_pkg::*;

    localparam int NCHAR = 2 ** CHAR_W;

    logic [IDX_W-1:0] w_mod_tab [NCHAR];
    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_eos;

    // character folded into the table range, worked out at elaboration
    for (genvar c = 0; c < NCHAR; c++) begin : g_mod
        assign w_mod_tab[c] = IDX_W'(c % ALPHABET_SIZE);
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_idx   = r_idx;
    assign o_eos   = r_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_idx <= w_mod_tab[i_character];
            r_eos <= i_end_of_string;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ldrt_queue.sv @@
`default_nettype none

module ldrt_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output      logic             o_push_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_valid,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_data
);
    import ldrt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_data       = r_store[r_rd_ptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ldrt_back.sv @@
`default_nettype none

module ldrt_back #(
    parameter int ALPHABET_SIZE     = ldrt_pkg::ALPHABET_DEF,
    parameter int MAX_STRING_LENGTH = ldrt_pkg::MAX_LENGTH_DEF,
    parameter int IDX_W             = $clog2(ALPHABET_SIZE)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    output      logic             o_q_pop,
    input  wire logic [IDX_W-1:0] i_q_idx,
    input  wire logic             i_q_eos,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      ldrt_pkg::t_res   o_res
);
    import ldrt_pkg::*;

    localparam int POS_W = (MAX_STRING_LENGTH > 1) ? $clog2(MAX_STRING_LENGTH + 1) : 1;

    // position table: seen bits in flops, positions in a memory
    logic [LEN_W-1:0]         r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_seen;

    logic [POS_W-1:0] r_pos;
    logic [LEN_W-1:0] r_wstart;
    logic [LEN_W-1:0] r_best;
    logic             r_ovf;

    // item waiting for execution with its table read
    logic             r_b_valid;
    logic [IDX_W-1:0] r_b_idx;
    logic             r_b_eos;
    logic [LEN_W-1:0] r_rd;
    logic             r_fwd_hit;
    logic [LEN_W-1:0] r_fwd_pos;

    logic             r_o_valid;
    t_res             r_res;

    logic             w_exec;
    logic             w_write;
    logic             w_ovf_now;
    logic [LEN_W-1:0] w_pos16;
    logic [LEN_W-1:0] w_entry;
    logic [LEN_W-1:0] w_ws_new;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_best_new;

    assign w_exec    = r_b_valid && (!r_o_valid || i_ready);
    assign o_q_pop   = i_q_valid && (!r_b_valid || w_exec);
    assign w_ovf_now = r_ovf || (r_pos >= POS_W'(MAX_STRING_LENGTH));
    assign w_write   = w_exec && !w_ovf_now;
    assign w_pos16   = LEN_W'(r_pos);

    always_comb begin
        // entry written by the item just ahead is not in the registered read
        w_entry    = r_fwd_hit ? r_fwd_pos : r_rd;
        w_ws_new   = (r_seen[r_b_idx] && (w_entry >= r_wstart)) ? w_entry + 1'b1 : r_wstart;
        w_len      = w_pos16 - w_ws_new + 1'b1;
        w_best_new = (w_len > r_best) ? w_len : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_seen    <= '0;
            r_pos     <= '0;
            r_wstart  <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_exec) begin
                r_b_valid <= 1'b0;
            end
            if (w_exec) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_exec) begin
                if (r_b_eos) begin
                    r_seen   <= '0;
                    r_pos    <= '0;
                    r_wstart <= '0;
                    r_best   <= '0;
                    r_ovf    <= 1'b0;
                end else if (w_ovf_now) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_seen[r_b_idx] <= 1'b1;
                    r_pos           <= r_pos + 1'b1;
                    r_wstart        <= w_ws_new;
                    r_best          <= w_best_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_b_idx] <= w_pos16;
        end
        if (o_q_pop) begin
            r_rd      <= r_mem[i_q_idx];
            r_b_idx   <= i_q_idx;
            r_b_eos   <= i_q_eos;
            r_fwd_hit <= w_write && (r_b_idx == i_q_idx);
            r_fwd_pos <= w_pos16;
        end
        if (w_exec) begin
            r_res.window_length  <= w_ovf_now ? '0 : w_len;
            r_res.longest_so_far <= w_ovf_now ? '0 : w_best_new;
            r_res.is_last        <= r_b_eos;
            r_res.overflow       <= w_ovf_now;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import ldrt_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_CHARS    = 310;
    localparam int BURST_CHARS    = 80;
    localparam int TAIL_CHARS     = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int EOS            = 128;

    // bit 7 marks the last character of a string
    localparam int DIRECTED [23] = '{
        0 | EOS,
        127 | EOS,
        1, 2, 3, 1, 2, 3, 2, 2 | EOS,
        127, 127, 0, 0 | EOS,
        5, 6, 6, 5 | EOS,
        85, 42 | EOS,
        42, 85, 85 | EOS
    };

    // longest repeat-free run predictor and the results it still waits for
    class run_scoreboard;
        logic [LEN_W:0]   last_seen [ALPHABET_DEF];
        logic [LEN_W-1:0] win_start;
        logic [LEN_W-1:0] best;
        int unsigned      pos;
        bit               over;
        t_res             expected_q [$];
        int               failures;

        function new();
            failures = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (last_seen[i]) last_seen[i] = '0;
            win_start = '0;
            best      = '0;
            pos       = 0;
            over      = 1'b0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void note_request(logic [CHAR_W-1:0] ch, logic eos);
            t_res             exp_res;
            int               idx;
            logic [LEN_W-1:0] here;
            exp_res = '0;
            idx     = int'(ch) % ALPHABET_DEF;
            if (!over && pos >= MAX_LENGTH_DEF) over = 1'b1;
            // once too long, the state stays frozen until the end of the string
            if (!over) begin
                here = LEN_W'(pos);
                if (last_seen[idx][LEN_W] && last_seen[idx][LEN_W-1:0] >= win_start)
                    win_start = last_seen[idx][LEN_W-1:0] + 1'b1;
                last_seen[idx] = {1'b1, here};
                exp_res.window_length = here - win_start + 1'b1;
                if (exp_res.window_length > best) best = exp_res.window_length;
                exp_res.longest_so_far = best;
                pos++;
            end
            exp_res.is_last  = eos;
            exp_res.overflow = over;
            expected_q.push_back(exp_res);
            if (eos) clear_string();
        endfunction

        function void compare_field(string field, logic [LEN_W-1:0] want,
                                    logic [LEN_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
            end else begin
                want = expected_q.pop_front();
                compare_field("window_length", want.window_length, got.window_length);
                compare_field("longest_so_far", want.longest_so_far, got.longest_so_far);
                compare_field("is_last", LEN_W'(want.is_last), LEN_W'(got.is_last));
                compare_field("overflow", LEN_W'(want.overflow), LEN_W'(got.overflow));
            end
        endfunction
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_valid         = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_character     = '0;
    logic              i_end_of_string = 1'b0;
    logic              o_valid;
    logic              i_ready         = 1'b0;
    logic [LEN_W-1:0]  o_window_length;
    logic [LEN_W-1:0]  o_longest_so_far;
    logic              o_is_last;
    logic              o_overflow;

    run_scoreboard sb = new();

    int unsigned tx_idle_pct  = 15;
    int unsigned rx_idle_pct  = 74;
    int unsigned hold_token   = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned chars_sent   = 0;

    longest_distinct_run_tracker_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_character      (i_character),
        .i_end_of_string  (i_end_of_string),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_window_length  (o_window_length),
        .o_longest_so_far (o_longest_so_far),
        .o_is_last        (o_is_last),
        .o_overflow       (o_overflow)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off whenever the token moves
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // outputs are stable between edges, so sample on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            sb.check_result({o_window_length, o_longest_so_far, o_is_last, o_overflow});
    end

    always @(negedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eos);
        bit accepted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_character     <= ch;
        i_end_of_string <= eos;
        do begin
            @(negedge i_clk);
            accepted = (o_ready === 1'b1);
            if (accepted) sb.note_request(ch, eos);
            @(posedge i_clk);
        end while (!accepted);
        chars_sent++;
    endtask

    task automatic send_random_string(input int max_len);
        int                kind;
        int                len;
        int                span;
        int                pick;
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] tmp;
        logic [CHAR_W-1:0] order [ALPHABET_DEF];
        kind = $urandom_range(9);
        base = CHAR_W'($urandom_range(127));
        if (kind < 5) begin
            len  = $urandom_range(1, 12);
            span = $urandom_range(1, 15);
        end else if (kind < 8) begin
            len  = $urandom_range(13, 60);
            span = $urandom_range(8, 127);
        end else if (kind == 8) begin
            len  = $urandom_range(ALPHABET_DEF, ALPHABET_DEF + 12);
            span = 127;
        end else begin
            len  = $urandom_range(150, 300);
            span = $urandom_range(32, 127);
        end
        if (len > max_len) len = max_len;
        // shuffled alphabet gives a window covering every character
        for (int i = 0; i < ALPHABET_DEF; i++) order[i] = CHAR_W'(i);
        for (int i = ALPHABET_DEF - 1; i > 0; i--) begin
            pick        = $urandom_range(i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        for (int i = 0; i < len; i++) begin
            if (kind == 8 && i < ALPHABET_DEF)
                send_char(order[i], i == len - 1);
            else
                send_char(base + CHAR_W'($urandom_range(span)), i == len - 1);
        end
    endtask

    task automatic send_random_chars(input int unsigned count);
        int unsigned first;
        first = chars_sent;
        while (chars_sent - first < count)
            send_random_string(int'(count - (chars_sent - first)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) send_char(DIRECTED[k][CHAR_W-1:0], DIRECTED[k][CHAR_W]);
        send_random_chars(PHASE_CHARS);
        wait_drained();

        tx_idle_pct = 74;
        rx_idle_pct <= 15;
        send_random_chars(PHASE_CHARS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        // receiver holds off while requests keep coming, so the input backs up
        hold_token <= hold_token + 1;
        send_random_chars(BURST_CHARS);
        wait_drained();
        send_random_chars(PHASE_CHARS);

        send_random_string(TAIL_CHARS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
